// File: sv/amt_pkg.sv
// ---------------------------------------------------------------------------
// Adaptive mean threshold package
// Shared types, register codes and default sizes for the threshold block.
// ---------------------------------------------------------------------------
package amt_pkg;

  // Default store geometry and window limit.
  localparam int DEF_MAX_WIDTH       = 256;
  localparam int DEF_MAX_HEIGHT      = 256;
  localparam int DEF_MAX_HALF_WINDOW = 7;

  // Configuration port.
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_WINDOW  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET       = 4'd3;

  // Register field widths and reset values.
  localparam int DIM_W = 9;
  localparam int HW_W  = 3;
  localparam int OFF_W = 9;

  localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH  = 9'd256;
  localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT = 9'd256;
  localparam logic [HW_W-1:0]  RST_HALF_WINDOW  = 3'd1;
  localparam logic [OFF_W-1:0] RST_OFFSET       = 9'd0;

  // Largest half window that the register can express.
  localparam int HW_REG_MAX = 7;

  // Threshold arithmetic: mean (0..255) minus offset (-256..255).
  localparam int THR_W = 11;

  localparam logic [7:0] PIX_WHITE = 8'hFF;
  localparam logic [7:0] PIX_BLACK = 8'h00;

  // Request codes.
  localparam logic REQ_LOAD     = 1'b0;
  localparam logic REQ_CLASSIFY = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [7:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic       last_pixel;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_POS,
    ST_BOUNDS,
    ST_BASE,
    ST_WINDOW,
    ST_DRAIN,
    ST_MEAN_START,
    ST_RESULT
  } state_e;

endpackage

// File: sv/adaptive_mean_threshold.sv
// Load beats are taken one per cycle while no classify beat is in progress, and
// complete in the cycle they are accepted. A classify beat runs the position
// divide, the clipped window scan and the mean divide, using the shared restoring
// divider and the single store read port. The result waits in an output register.
// Reset clears the registers to their reset values and both positions to zero;
// the frame store is not cleared and reads as undefined until loaded.
// ---------------------------------------------------------------------------
// Adaptive mean threshold
// Frame store with raster-order load, and a sequencer that binarises each
// pixel against the mean of its clipped square window less an offset.
// ---------------------------------------------------------------------------
module adaptive_mean_threshold #(
  parameter int MAX_WIDTH       = amt_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT      = amt_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_HALF_WINDOW = amt_pkg::DEF_MAX_HALF_WINDOW
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  amt_pkg::in_item_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output amt_pkg::out_item_t             out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [amt_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [amt_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  // Store geometry. Positions index the store directly.
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW    = $clog2(DEPTH + 1);
  localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WCW   = $clog2(MAX_WIDTH + 1);
  localparam int HCW   = $clog2(MAX_HEIGHT + 1);
  localparam int CW    = ((WCW > HCW) ? WCW : HCW) + 4;

  // Window accumulation.
  localparam int HWM  = (MAX_HALF_WINDOW < amt_pkg::HW_REG_MAX) ?
                        MAX_HALF_WINDOW : amt_pkg::HW_REG_MAX;
  localparam int WSZ  = (2 * HWM + 1) * (2 * HWM + 1);
  localparam int SUMW = $clog2(WSZ * 255 + 1);
  localparam int CNTW = $clog2(WSZ + 1);

  // Shared divider: dividend is a position or a sum, divisor a width or a count.
  localparam int DIV_W  = (AW > SUMW) ? AW : SUMW;
  localparam int DVS_W  = (WCW > CNTW) ? WCW : CNTW;
  localparam int DCNT_W = $clog2(DIV_W + 1);

  // -------------------------------------------------------------------------
  // Configuration registers. The port never pushes back.
  // -------------------------------------------------------------------------
  logic [amt_pkg::DIM_W-1:0] width_q, height_q;
  logic [amt_pkg::HW_W-1:0]  half_q;
  logic [amt_pkg::OFF_W-1:0] offset_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= amt_pkg::RST_IMAGE_WIDTH;
      height_q <= amt_pkg::RST_IMAGE_HEIGHT;
      half_q   <= amt_pkg::RST_HALF_WINDOW;
      offset_q <= amt_pkg::RST_OFFSET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        amt_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data_i[amt_pkg::DIM_W-1:0];
        amt_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data_i[amt_pkg::DIM_W-1:0];
        amt_pkg::REG_HALF_WINDOW:  half_q   <= cfg_data_i[amt_pkg::HW_W-1:0];
        amt_pkg::REG_OFFSET:       offset_q <= cfg_data_i[amt_pkg::OFF_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective geometry: a zero dimension acts as one, and everything is
  // clamped to what the store and the window limit allow.
  logic [WCW-1:0]            w_eff;
  logic [HCW-1:0]            h_eff;
  logic [amt_pkg::HW_W-1:0]  r_eff;
  logic [SW-1:0]             size;

  always_comb begin
    if (width_q == '0) begin
      w_eff = WCW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_eff = WCW'(MAX_WIDTH);
    end else begin
      w_eff = WCW'(width_q);
    end
    if (height_q == '0) begin
      h_eff = HCW'(1);
    end else if (32'(height_q) > MAX_HEIGHT) begin
      h_eff = HCW'(MAX_HEIGHT);
    end else begin
      h_eff = HCW'(height_q);
    end
    if (32'(half_q) > MAX_HALF_WINDOW) begin
      r_eff = amt_pkg::HW_W'(MAX_HALF_WINDOW);
    end else begin
      r_eff = half_q;
    end
  end

  logic [WCW+HCW-1:0] size_full;
  assign size_full = (WCW+HCW)'(w_eff) * (WCW+HCW)'(h_eff);
  assign size      = size_full[SW-1:0];

  // -------------------------------------------------------------------------
  // Positions. A position left beyond the image by a geometry change
  // restarts at zero before it is used.
  // -------------------------------------------------------------------------
  logic [AW-1:0] load_pos_q, class_pos_q;
  logic [AW-1:0] load_eff, class_eff, load_next, class_next;

  always_comb begin
    load_eff   = (SW'(load_pos_q) >= size) ? '0 : load_pos_q;
    class_eff  = (SW'(class_pos_q) >= size) ? '0 : class_pos_q;
    load_next  = ((SW'(load_eff) + SW'(1)) >= size) ? '0 : load_eff + AW'(1);
    class_next = ((SW'(class_eff) + SW'(1)) >= size) ? '0 : class_eff + AW'(1);
  end

  // -------------------------------------------------------------------------
  // Sequencer.
  // -------------------------------------------------------------------------
  amt_pkg::state_e state_q, state_d;

  logic in_accept, load_accept, class_accept;
  logic out_free;
  logic div_start;
  logic [DIV_W-1:0] div_dvd;
  logic [DVS_W-1:0] div_dvs;
  logic [DCNT_W-1:0] div_cnt_q;
  logic div_busy;
  logic [XW-1:0] i_q, x0_q, x1_q;
  logic [YW-1:0] j_q, y1_q;
  logic last_col, last_row;

  logic [SUMW-1:0] sum_q;
  logic [CNTW-1:0] cnt_q;

  assign in_stall_o   = (state_q != amt_pkg::ST_IDLE);
  assign in_accept    = in_valid_i && !in_stall_o;
  assign load_accept  = in_accept && (in_data_i.req_type == amt_pkg::REQ_LOAD);
  assign class_accept = in_accept && (in_data_i.req_type == amt_pkg::REQ_CLASSIFY);
  assign out_free     = !out_valid_o || !out_stall_i;
  assign div_busy     = (div_cnt_q != '0);
  assign last_col     = (i_q == x1_q);
  assign last_row     = (j_q == y1_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= amt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // The divider is started twice per classify: once to split the position
  // into column and row, once to form the window mean.
  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    div_dvd   = DIV_W'(class_eff);
    div_dvs   = DVS_W'(w_eff);
    case (state_q)
      amt_pkg::ST_IDLE: begin
        if (class_accept) begin
          div_start = 1'b1;
          state_d   = amt_pkg::ST_DIV_POS;
        end
      end
      amt_pkg::ST_DIV_POS: begin
        if (!div_busy) begin
          state_d = amt_pkg::ST_BOUNDS;
        end
      end
      amt_pkg::ST_BOUNDS: begin
        state_d = amt_pkg::ST_BASE;
      end
      amt_pkg::ST_BASE: begin
        state_d = amt_pkg::ST_WINDOW;
      end
      amt_pkg::ST_WINDOW: begin
        if (last_col && last_row) begin
          state_d = amt_pkg::ST_DRAIN;
        end
      end
      amt_pkg::ST_DRAIN: begin
        state_d = amt_pkg::ST_MEAN_START;
      end
      amt_pkg::ST_MEAN_START: begin
        div_start = 1'b1;
        div_dvd   = DIV_W'(sum_q);
        div_dvs   = DVS_W'(cnt_q);
        state_d   = amt_pkg::ST_RESULT;
      end
      amt_pkg::ST_RESULT: begin
        if (!div_busy && out_free) begin
          state_d = amt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = amt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_pos_q  <= '0;
      class_pos_q <= '0;
    end else if (load_accept) begin
      load_pos_q  <= load_next;
      class_pos_q <= class_eff;
    end else if (class_accept) begin
      load_pos_q  <= load_eff;
      class_pos_q <= class_next;
    end
  end

  // -------------------------------------------------------------------------
  // Shared restoring divider, one quotient bit per cycle. The quotient
  // register shifts the dividend out as the quotient bits come in.
  // -------------------------------------------------------------------------
  logic [DIV_W-1:0] div_quo_q;
  logic [DVS_W-1:0] div_rem_q, div_dvs_q;
  logic [DVS_W+1:0] div_shift, div_trial;

  assign div_shift = {1'b0, div_rem_q, div_quo_q[DIV_W-1]};
  assign div_trial = div_shift - {2'b00, div_dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (div_start) begin
      div_cnt_q <= DCNT_W'(DIV_W);
    end else if (div_busy) begin
      div_cnt_q <= div_cnt_q - DCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      div_quo_q <= div_dvd;
      div_rem_q <= '0;
      div_dvs_q <= div_dvs;
    end else if (div_busy) begin
      if (div_trial[DVS_W+1]) begin
        div_rem_q <= div_shift[DVS_W-1:0];
        div_quo_q <= {div_quo_q[DIV_W-2:0], 1'b0};
      end else begin
        div_rem_q <= div_trial[DVS_W-1:0];
        div_quo_q <= {div_quo_q[DIV_W-2:0], 1'b1};
      end
    end
  end

  // -------------------------------------------------------------------------
  // Window bounds, clipped to the image. Column is the remainder and row
  // the quotient of the position divide.
  // -------------------------------------------------------------------------
  logic [CW-1:0] cx, cy, cr, cx1, cy1;
  logic [CW-1:0] bx0, bx1, by0, by1;

  always_comb begin
    cx  = CW'(div_rem_q[XW-1:0]);
    cy  = CW'(div_quo_q[YW-1:0]);
    cr  = CW'(r_eff);
    cx1 = cx + cr;
    cy1 = cy + cr;
    bx0 = (cx >= cr) ? cx - cr : '0;
    by0 = (cy >= cr) ? cy - cr : '0;
    bx1 = (cx1 > CW'(w_eff) - CW'(1)) ? CW'(w_eff) - CW'(1) : cx1;
    by1 = (cy1 > CW'(h_eff) - CW'(1)) ? CW'(h_eff) - CW'(1) : cy1;
  end

  // -------------------------------------------------------------------------
  // Frame store: one write port for loads, one registered read port shared
  // by the centre read and the window scan.
  // -------------------------------------------------------------------------
  logic [7:0]    store_mem [DEPTH];
  logic [7:0]    rd_data_q;
  logic [AW-1:0] rd_addr, row_base_q, pos_q;
  logic          acc_valid_q;

  assign rd_addr = (state_q == amt_pkg::ST_WINDOW) ? row_base_q + AW'(i_q) : pos_q;

  always_ff @(posedge clk_i) begin
    if (load_accept) begin
      store_mem[load_eff] <= in_data_i.pixel_in;
    end
    rd_data_q <= store_mem[rd_addr];
  end

  logic [WCW+YW-1:0] base_prod;
  assign base_prod = (WCW+YW)'(j_q) * (WCW+YW)'(w_eff);

  logic [7:0] center_q;
  logic       last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_valid_q <= 1'b0;
    end else begin
      acc_valid_q <= (state_q == amt_pkg::ST_WINDOW);
    end
  end

  // Window scan: column by column, then a row step that adds the width to
  // the row base. Read data lands in the next cycle and is accumulated then.
  always_ff @(posedge clk_i) begin
    if (class_accept) begin
      pos_q  <= class_eff;
      last_q <= (SW'(class_eff) == size - SW'(1));
    end
    case (state_q)
      amt_pkg::ST_BOUNDS: begin
        x0_q <= bx0[XW-1:0];
        x1_q <= bx1[XW-1:0];
        y1_q <= by1[YW-1:0];
        i_q  <= bx0[XW-1:0];
        j_q  <= by0[YW-1:0];
      end
      amt_pkg::ST_BASE: begin
        center_q   <= rd_data_q;
        row_base_q <= base_prod[AW-1:0];
        sum_q      <= '0;
        cnt_q      <= '0;
      end
      amt_pkg::ST_WINDOW: begin
        if (last_col) begin
          i_q        <= x0_q;
          j_q        <= j_q + YW'(1);
          row_base_q <= row_base_q + AW'(w_eff);
        end else begin
          i_q <= i_q + XW'(1);
        end
      end
      default: ;
    endcase
    if (acc_valid_q) begin
      sum_q <= sum_q + SUMW'(rd_data_q);
      cnt_q <= cnt_q + CNTW'(1);
    end
  end

  // -------------------------------------------------------------------------
  // Threshold compare and output register. The pixel is white when it is
  // strictly above the mean less the offset.
  // -------------------------------------------------------------------------
  logic signed [amt_pkg::THR_W-1:0] thr, center_s;
  logic                             white;

  always_comb begin
    thr      = $signed({3'b000, div_quo_q[7:0]})
               - $signed({{2{offset_q[amt_pkg::OFF_W-1]}}, offset_q});
    center_s = $signed({3'b000, center_q});
    white    = (center_s > thr);
  end

  logic      out_valid_q;
  amt_pkg::out_item_t out_data_q;
  logic      result_load;

  assign result_load = (state_q == amt_pkg::ST_RESULT) && !div_busy && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (result_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (result_load) begin
      out_data_q.pixel_out  <= white ? amt_pkg::PIX_WHITE : amt_pkg::PIX_BLACK;
      out_data_q.last_pixel <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
